[src/b64se_pkg.sv]
// b64se_pkg: shared types, constants and the character map for the Base64
// stream encoder. No dependencies; imported by every module of the block.
package b64se_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] PHASE_START = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [5:0] SIX_BITS = 6'h3F;

  // one output character slot: a 6-bit code or a pad
  typedef struct packed {
    logic       pad;
    logic [5:0] code;
  } slot_t;

  // work handed from front to back: slots in emit order, index of the last one
  typedef struct packed {
    slot_t [3:0] slots;
    logic  [1:0] last_idx;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] code, input logic variant);
    logic [7:0] c;
    c = {2'b00, code & SIX_BITS};
    if (c < 8'd26) begin
      enc_char = 8'h41 + c;
    end else if (c < 8'd52) begin
      enc_char = 8'h61 + (c - 8'd26);
    end else if (c < 8'd62) begin
      enc_char = 8'h30 + (c - 8'd52);
    end else if (c == 8'd62) begin
      enc_char = 8'h2B;
    end else begin
      enc_char = variant ? 8'h2D : 8'h2F;
    end
  endfunction

endpackage

[src/base64_stream_encoder.sv]
// base64_stream_encoder: top level of the streaming Base64 encoder.
// Path of a byte: job queue, current-job register, output register.
// Throughput: one character per cycle out of the back end when not stalled;
// a byte gives 1 to 4 characters (1, 1, 2 per group, 4 or 3 with last flag).
// Bytes are accepted every cycle while the job queue has room.
// Reset (rst, synchronous): group phase to start, queue empty, output idle.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input byte stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  // output character stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] code_char
  output logic       m_axis_tlast,   // last_char
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data        // alphabet_variant
);
  import b64se_pkg::*;

  logic alphabet_variant;
  logic push, pop, queue_full, head_valid;
  job_t push_job, head_job;

  // configuration is always taken; a write is registered and takes effect in the following cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_variant <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      alphabet_variant <= cfg_data;
    end
  end

  // front end: classifies each byte by group phase into a job of codes/pads
  b64se_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .queue_full (queue_full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_job   (push_job)
  );

  // job queue decouples byte acceptance from character emission
  b64se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back end: one character per cycle into the output register when not stalled
  b64se_back u_back (
    .clk        (clk),
    .rst        (rst),
    .variant    (alphabet_variant),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_char   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_ready  (m_axis_tready)
  );

endmodule

[src/b64se_front.sv]
// b64se_front: accepts bytes, tracks group phase and leftover bits, and
// splits each byte into a job of 6-bit codes and pads. Uses b64se_pkg.
module b64se_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             queue_full,
  output logic             in_ready,
  output logic             push,
  output b64se_pkg::job_t  push_job
);
  import b64se_pkg::*;

  logic [1:0] group_phase, group_phase_next;
  logic [3:0] leftover_bits, leftover_bits_next;
  slot_t      pad_slot;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign pad_slot = '{pad: 1'b1, code: 6'd0};

  always_comb begin
    push_job           = '0;
    group_phase_next   = PHASE_START;
    leftover_bits_next = 4'd0;
    case (group_phase)
      PHASE_ONE: begin
        push_job.slots[0] = '{pad: 1'b0, code: {leftover_bits[1:0], in_byte[7:4]}};
        if (in_last) begin
          push_job.slots[1] = '{pad: 1'b0, code: {in_byte[3:0], 2'b00}};
          push_job.slots[2] = pad_slot;
          push_job.last_idx = 2'd2;
        end else begin
          push_job.last_idx  = 2'd0;
          group_phase_next   = PHASE_TWO;
          leftover_bits_next = in_byte[3:0];
        end
      end
      PHASE_TWO: begin
        push_job.slots[0] = '{pad: 1'b0, code: {leftover_bits, in_byte[7:6]}};
        push_job.slots[1] = '{pad: 1'b0, code: in_byte[5:0]};
        push_job.last_idx = 2'd1;
      end
      default: begin
        // group start (the unused phase code behaves the same)
        push_job.slots[0] = '{pad: 1'b0, code: in_byte[7:2]};
        if (in_last) begin
          push_job.slots[1] = '{pad: 1'b0, code: {in_byte[1:0], 4'b0000}};
          push_job.slots[2] = pad_slot;
          push_job.slots[3] = pad_slot;
          push_job.last_idx = 2'd3;
        end else begin
          push_job.last_idx  = 2'd0;
          group_phase_next   = PHASE_ONE;
          leftover_bits_next = {2'b00, in_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase   <= PHASE_START;
      leftover_bits <= 4'd0;
    end else if (push) begin
      group_phase   <= group_phase_next;
      leftover_bits <= leftover_bits_next;
    end
  end

endmodule

[src/b64se_queue.sv]
// b64se_queue: short job queue between front and back so each side can
// stall on its own. Uses b64se_pkg for the job type.
module b64se_queue #(
  parameter int DEPTH = b64se_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64se_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output b64se_pkg::job_t head_job
);
  import b64se_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/b64se_back.sv]
// b64se_back: walks the slots of the current job, maps codes to ASCII and
// drives the registered output stream. Uses b64se_pkg.
module b64se_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            variant,
  input  logic            head_valid,
  input  b64se_pkg::job_t head_job,
  output logic            pop,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_last,
  input  logic            out_ready
);
  import b64se_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       adv, cur_done;
  slot_t      slot;

  assign slot     = cur.slots[idx];
  assign adv      = cur_valid && (!out_valid || out_ready);
  assign cur_done = adv && (idx == cur.last_idx);
  assign pop      = head_valid && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
    if (adv) begin
      out_char <= slot.pad ? PAD_CHAR : enc_char(slot.code, variant);
      out_last <= (idx == cur.last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (adv) begin
        idx <= idx + 2'd1;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/b64se_checker.sv]
// b64se_checker: port-level checks for base64_stream_encoder, attached by
// the bind at the end of this file. No package dependencies.
module b64se_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled output holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // reset leaves output idle and input open
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("bad state after reset");

  // only Base64 alphabet characters or the pad come out
  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tdata >= 8'h41) && (m_axis_tdata <= 8'h5A)) ||
      ((m_axis_tdata >= 8'h61) && (m_axis_tdata <= 8'h7A)) ||
      ((m_axis_tdata >= 8'h30) && (m_axis_tdata <= 8'h39)) ||
      (m_axis_tdata == 8'h2B) || (m_axis_tdata == 8'h2F) ||
      (m_axis_tdata == 8'h2D) || (m_axis_tdata == 8'h3D))
    else $error("character outside alphabet");

  // a pad that is not the final character is followed by another pad
  a_pad_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (m_axis_tdata == 8'h3D) && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata == 8'h3D))
    else $error("pad run broken");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (.*);
